@@ rtl/skt_pkg.sv @@
// Shared types, codes and default sizes for the sorted key table lookup unit.
package skt_pkg;

    localparam int DEPTH_DEF        = 64;
    localparam int KEY_BITS_DEF     = 16;
    localparam int HANDLER_BITS_DEF = 16;

    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED = 3'd0,
        ST_CLOSED = 3'd1,
        ST_HIT    = 3'd2,
        ST_MISS   = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   entry_count;
    } result_t;

endpackage

@@ rtl/sorted_key_table_lookup_unit.sv @@
// Top level of the sorted key table lookup unit: entry memory, sequencer, output register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------------
//   in      | in_valid  | in_stall  | command, key, handler_id
//   out     | out_valid | out_stall | status, position, found_handler, entry_count
//
// A lookup makes p binary search probes (p <= ceil(log2(count + 1)), at most 7 for
// 64 entries), one probe per memory read. A closing load runs the bubble sort: each
// pass makes one compare and write per element on the separate write and read ports
// of the memory. Reset clears the state, count and the closed flag; the entry memory
// is never cleared. One word is in work at a time; the output register holds a
// finished word while the next one is taken and worked on, and out_stall holds the
// sequencer only when a second result is ready.
module sorted_key_table_lookup_unit
    import skt_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int HANDLER_BITS = HANDLER_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    command,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [HANDLER_BITS-1:0] handler_id,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [POS_W-1:0]        position,
    output logic [HANDLER_BITS-1:0] found_handler,
    output logic [COUNT_W-1:0]      entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int ENT_W = KEY_BITS + HANDLER_BITS;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [ENT_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENT_W-1:0]        ram_rdata;

    logic                    res_valid;
    logic                    res_take;
    result_t                 res;
    logic [HANDLER_BITS-1:0] res_handler;

    logic                    out_valid_reg, out_valid_next;
    result_t                 out_res_reg;
    logic [HANDLER_BITS-1:0] out_handler_reg;

    skt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    skt_engine #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .HANDLER_BITS (HANDLER_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .key         (key),
        .handler_id  (handler_id),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .res_handler (res_handler),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg     <= res;
            out_handler_reg <= res_handler;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign position      = out_res_reg.position;
    assign found_handler = out_handler_reg;
    assign entry_count   = out_res_reg.entry_count;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall
    ) else $error("input taken while a word is in work");

    a_fill_on_no_hit: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_HIT) |-> (position == '0) && (found_handler == '0)
    ) else $error("position or handler nonzero without a hit");

    a_status_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_STORED) || (status == ST_CLOSED) ||
                      (status == ST_HIT) || (status == ST_MISS) || (status == ST_FULL)
    ) else $error("undefined status code");

    a_result_not_lost: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && out_valid && out_stall |=> res_valid
    ) else $error("finished result dropped while output held");
`endif

endmodule

@@ rtl/skt_ram.sv @@
// Generic single-write, single-read memory with registered read data.
module skt_ram
    import skt_pkg::*;
#(
    parameter int WIDTH = KEY_BITS_DEF + HANDLER_BITS_DEF,
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/skt_engine.sv @@
// Load, bubble sort and binary search sequencer around the entry memory.
module skt_engine
    import skt_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int HANDLER_BITS = HANDLER_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [KEY_BITS-1:0]              key,
    input  logic [HANDLER_BITS-1:0]          handler_id,
    output logic                             res_valid,
    input  logic                             res_take,
    output result_t                          res,
    output logic [HANDLER_BITS-1:0]          res_handler,
    output logic                             ram_we,
    output logic [$clog2(DEPTH)-1:0]         ram_waddr,
    output logic [KEY_BITS+HANDLER_BITS-1:0] ram_wdata,
    output logic [$clog2(DEPTH)-1:0]         ram_raddr,
    input  logic [KEY_BITS+HANDLER_BITS-1:0] ram_rdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = KEY_BITS + HANDLER_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PASS  = 8'b0000_0010,
        S_HEAD  = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_TAIL  = 8'b0001_0000,
        S_SRCH  = 8'b0010_0000,
        S_PROBE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     closed_reg, closed_next;
    logic [IDX_W-1:0]         end_reg, end_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic                     swapped_reg, swapped_next;
    logic [ENT_W-1:0]         cur_reg, cur_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hip_reg, hip_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [KEY_BITS-1:0]      skey_reg, skey_next;
    result_t                  res_reg, res_next;
    logic [HANDLER_BITS-1:0]  res_handler_reg, res_handler_next;

    logic [CNT_W-1:0]         cnt_eff;
    logic [CNT_W-1:0]         lo_n;
    logic [CNT_W-1:0]         hip_n;
    logic [CNT_W-1:0]         mid_n;
    logic [KEY_BITS-1:0]      rd_key;
    logic [HANDLER_BITS-1:0]  rd_handler;
    logic [KEY_BITS-1:0]      cur_key;

    assign rd_key     = ram_rdata[ENT_W-1:HANDLER_BITS];
    assign rd_handler = ram_rdata[HANDLER_BITS-1:0];
    assign cur_key    = cur_reg[ENT_W-1:HANDLER_BITS];
    assign cnt_eff    = closed_reg ? '0 : count_reg;

    assign in_stall    = (state_reg != S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res         = res_reg;
    assign res_handler = res_handler_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        closed_next      = closed_reg;
        end_next         = end_reg;
        i_next           = i_reg;
        swapped_next     = swapped_reg;
        cur_next         = cur_reg;
        lo_next          = lo_reg;
        hip_next         = hip_reg;
        mid_next         = mid_reg;
        skey_next        = skey_reg;
        res_next         = res_reg;
        res_handler_next = res_handler_reg;
        ram_we           = 1'b0;
        ram_waddr        = i_reg;
        ram_wdata        = cur_reg;
        ram_raddr        = '0;
        lo_n             = lo_reg;
        hip_n            = hip_reg;
        mid_n            = mid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next.position = '0;
                    res_handler_next  = '0;
                    if (command == CMD_LOOKUP)
                    begin
                        skey_next = key;
                        if (closed_reg && (count_reg != '0))
                        begin
                            lo_next    = '0;
                            hip_next   = count_reg;
                            state_next = S_SRCH;
                        end
                        else
                        begin
                            res_next.status      = ST_MISS;
                            res_next.entry_count = COUNT_W'(count_reg);
                            state_next           = S_DONE;
                        end
                    end
                    else
                    begin
                        closed_next = 1'b0;
                        count_next  = cnt_eff;
                        if (key == '0)
                        begin
                            res_next.entry_count = COUNT_W'(cnt_eff);
                            if (cnt_eff <= CNT_W'(1))
                            begin
                                closed_next     = 1'b1;
                                res_next.status = ST_CLOSED;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                end_next   = IDX_W'(cnt_eff - CNT_W'(1));
                                state_next = S_PASS;
                            end
                        end
                        else if (cnt_eff == CNT_W'(DEPTH))
                        begin
                            res_next.status      = ST_FULL;
                            res_next.entry_count = COUNT_W'(cnt_eff);
                            state_next           = S_DONE;
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            ram_waddr            = IDX_W'(cnt_eff);
                            ram_wdata            = {key, handler_id};
                            count_next           = cnt_eff + CNT_W'(1);
                            res_next.status      = ST_STORED;
                            res_next.entry_count = COUNT_W'(cnt_eff + CNT_W'(1));
                            state_next           = S_DONE;
                        end
                    end
                end
            end
            S_PASS:
            begin
                ram_raddr    = '0;
                i_next       = '0;
                swapped_next = 1'b0;
                state_next   = S_HEAD;
            end
            S_HEAD:
            begin
                cur_next   = ram_rdata;
                ram_raddr  = i_reg + IDX_W'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // carry the larger entry forward, drop the smaller one in place
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                if (cur_key > rd_key)
                begin
                    ram_wdata    = ram_rdata;
                    swapped_next = 1'b1;
                end
                else
                begin
                    ram_wdata = cur_reg;
                    cur_next  = ram_rdata;
                end
                i_next    = i_reg + IDX_W'(1);
                ram_raddr = i_reg + IDX_W'(2);
                if ((i_reg + IDX_W'(1)) >= end_reg)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                ram_we    = 1'b1;
                ram_waddr = end_reg;
                ram_wdata = cur_reg;
                if (swapped_reg && (end_reg > IDX_W'(1)))
                begin
                    end_next   = end_reg - IDX_W'(1);
                    state_next = S_PASS;
                end
                else
                begin
                    closed_next     = 1'b1;
                    res_next.status = ST_CLOSED;
                    state_next      = S_DONE;
                end
            end
            S_SRCH:
            begin
                mid_n      = lo_reg + ((hip_reg - lo_reg) >> 1);
                ram_raddr  = IDX_W'(mid_n);
                mid_next   = mid_n;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (rd_key == skey_reg)
                begin
                    res_next.status      = ST_HIT;
                    res_next.position    = POS_W'(mid_reg);
                    res_next.entry_count = COUNT_W'(count_reg);
                    res_handler_next     = rd_handler;
                    state_next           = S_DONE;
                end
                else
                begin
                    if (skey_reg < rd_key)
                    begin
                        hip_n = mid_reg;
                    end
                    else
                    begin
                        lo_n = mid_reg + CNT_W'(1);
                    end
                    lo_next  = lo_n;
                    hip_next = hip_n;
                    mid_n    = lo_n + ((hip_n - lo_n) >> 1);
                    if (lo_n < hip_n)
                    begin
                        ram_raddr = IDX_W'(mid_n);
                        mid_next  = mid_n;
                    end
                    else
                    begin
                        res_next.status      = ST_MISS;
                        res_next.entry_count = COUNT_W'(count_reg);
                        state_next           = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg         <= end_next;
        i_reg           <= i_next;
        swapped_reg     <= swapped_next;
        cur_reg         <= cur_next;
        lo_reg          <= lo_next;
        hip_reg         <= hip_next;
        mid_reg         <= mid_next;
        skey_reg        <= skey_next;
        res_reg         <= res_next;
        res_handler_reg <= res_handler_next;
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the sorted key table lookup unit.
module tb
    import skt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT   = 500000;
    localparam int TAIL_CYCLES = 40;
    localparam int WORD_TARGET = 820;

    typedef struct {
        logic                        cmd;
        logic [KEY_BITS_DEF-1:0]     key;
        logic [HANDLER_BITS_DEF-1:0] handler;
    } table_word_t;

    typedef struct {
        status_t                     status;
        logic [POS_W-1:0]            position;
        logic [HANDLER_BITS_DEF-1:0] handler;
        logic [COUNT_W-1:0]          count;
    } table_answer_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        command = CMD_LOAD;
    logic [KEY_BITS_DEF-1:0]     key = '0;
    logic [HANDLER_BITS_DEF-1:0] handler_id = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic [POS_W-1:0]            position;
    logic [HANDLER_BITS_DEF-1:0] found_handler;
    logic [COUNT_W-1:0]          entry_count;

    table_word_t   word_q[$];
    table_answer_t answer_q[$];
    table_word_t   next_word;

    logic [KEY_BITS_DEF-1:0]     table_keys[DEPTH_DEF];
    logic [HANDLER_BITS_DEF-1:0] table_handlers[DEPTH_DEF];
    int                          table_count = 0;
    bit                          table_closed = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int hold_left = 0;
    int rx_cycles = 0;
    int cycle_count = 0;
    int mismatch_count = 0;

    sorted_key_table_lookup_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .key           (key),
        .handler_id    (handler_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .position      (position),
        .found_handler (found_handler),
        .entry_count   (entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void queue_word(logic c, logic [KEY_BITS_DEF-1:0] k,
                                       logic [HANDLER_BITS_DEF-1:0] h);
        table_word_t w;
        w.cmd = c;
        w.key = k;
        w.handler = h;
        word_q.push_back(w);
    endfunction

    function automatic void predict_table_answer(logic c, logic [KEY_BITS_DEF-1:0] k,
                                                 logic [HANDLER_BITS_DEF-1:0] h);
        table_answer_t a;
        int last;
        int i;
        int lo;
        int hi;
        int mid;
        int idx;
        bit swapped;
        logic [KEY_BITS_DEF-1:0] tk;
        logic [HANDLER_BITS_DEF-1:0] th;
        a.status = ST_MISS;
        a.position = '0;
        a.handler = '0;
        if (c == CMD_LOAD)
        begin
            if (table_closed)
            begin
                table_count = 0;
                table_closed = 1'b0;
            end
            if (k == '0)
            begin
                last = table_count - 1;
                do
                begin
                    swapped = 1'b0;
                    for (i = 0; i < last; i++)
                    begin
                        if (table_keys[i] > table_keys[i + 1])
                        begin
                            tk = table_keys[i];
                            th = table_handlers[i];
                            table_keys[i] = table_keys[i + 1];
                            table_handlers[i] = table_handlers[i + 1];
                            table_keys[i + 1] = tk;
                            table_handlers[i + 1] = th;
                            swapped = 1'b1;
                        end
                    end
                    last--;
                end
                while (swapped);
                table_closed = 1'b1;
                a.status = ST_CLOSED;
            end
            else if (table_count >= DEPTH_DEF)
            begin
                a.status = ST_FULL;
            end
            else
            begin
                table_keys[table_count] = k;
                table_handlers[table_count] = h;
                table_count++;
                a.status = ST_STORED;
            end
        end
        else if (table_closed && table_count > 0)
        begin
            lo = 0;
            hi = table_count - 1;
            idx = -1;
            while (lo <= hi && idx < 0)
            begin
                mid = lo + (hi - lo + 1) / 2;
                if (k == table_keys[mid])
                    idx = mid;
                else if (k < table_keys[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            if (idx >= 0)
            begin
                a.status = ST_HIT;
                a.position = POS_W'(idx);
                a.handler = table_handlers[idx];
            end
        end
        a.count = COUNT_W'(table_count);
        answer_q.push_back(a);
    endfunction

    // Sender: bursts of words with random gaps, payload held while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_table_answer(command, key, handler_id);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_q.size() != 0)
                begin
                    next_word = word_q.pop_front();
                    command <= next_word.cmd;
                    key <= next_word.key;
                    handler_id <= next_word.handler;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom % 4 == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(0, 12);
                        gap_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode, plus two long hold-offs.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            rx_cycles++;
            if (rx_cycles == 1500 || rx_cycles == 6000)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom % 4;
                    stall_left = $urandom_range(32, 256);
                end
                else
                begin
                    stall_left--;
                end
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom % 100) < 30;
                    2: out_stall <= ($urandom % 100) < 70;
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        table_answer_t a;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: st=%0d pos=%0d hdl=%h cnt=%0d",
                             status, position, found_handler, entry_count);
            end
            else
            begin
                a = answer_q.pop_front();
                if (status !== a.status || position !== a.position ||
                    found_handler !== a.handler || entry_count !== a.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp st=%0d pos=%0d hdl=%h cnt=%0d, ",
                                  "got st=%0d pos=%0d hdl=%h cnt=%0d"},
                                 a.status, a.position, a.handler, a.count,
                                 status, position, found_handler, entry_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int n;
        int m;
        int r;
        int pool_kind;
        int tables;
        int i;
        logic [KEY_BITS_DEF-1:0] k;
        logic [KEY_BITS_DEF-1:0] loaded[$];

        queue_word(CMD_LOOKUP, 16'h0001, 16'h0000);
        queue_word(CMD_LOAD,   16'h0000, 16'h0000);
        queue_word(CMD_LOOKUP, 16'hFFFF, 16'hFFFF);
        queue_word(CMD_LOAD,   16'h0000, 16'hFFFF);
        queue_word(CMD_LOAD,   16'hFFFF, 16'hFFFF);
        queue_word(CMD_LOAD,   16'h0001, 16'h0000);
        queue_word(CMD_LOAD,   16'h8000, 16'h1234);
        queue_word(CMD_LOAD,   16'h0001, 16'hAAAA);
        queue_word(CMD_LOAD,   16'h5555, 16'h5555);
        queue_word(CMD_LOOKUP, 16'h0001, 16'h0000);
        queue_word(CMD_LOAD,   16'h0000, 16'h7FFF);
        queue_word(CMD_LOOKUP, 16'hFFFF, 16'h0000);
        queue_word(CMD_LOOKUP, 16'h0001, 16'hFFFF);
        queue_word(CMD_LOOKUP, 16'h0000, 16'h0000);
        queue_word(CMD_LOOKUP, 16'h2AAA, 16'h0000);
        queue_word(CMD_LOOKUP, 16'h8000, 16'h0000);
        queue_word(CMD_LOOKUP, 16'h5555, 16'h0000);
        queue_word(CMD_LOAD,   16'h0007, 16'h0C3C);
        queue_word(CMD_LOOKUP, 16'h0007, 16'h0000);

        tables = 0;
        while (word_q.size() < WORD_TARGET)
        begin
            r = $urandom % 100;
            if (tables == 0)
                n = DEPTH_DEF + 6;
            else if (r < 75)
                n = $urandom_range(1, 12);
            else if (r < 95)
                n = $urandom_range(13, 40);
            else
                n = $urandom_range(60, 70);
            pool_kind = $urandom % 3;
            loaded.delete();
            for (i = 0; i < n; i++)
            begin
                if ($urandom % 20 == 0)
                    queue_word(CMD_LOOKUP, 16'($urandom), 16'($urandom));
                if (pool_kind == 1 || (pool_kind == 2 && $urandom % 2 == 0))
                    k = 16'($urandom_range(1, 16));
                else
                    k = 16'($urandom_range(1, 65535));
                queue_word(CMD_LOAD, k, 16'($urandom));
                loaded.push_back(k);
            end
            // drop the close now and then so the next loads extend this table
            if ($urandom % 10 != 0)
                queue_word(CMD_LOAD, 16'h0000, 16'($urandom));
            if ($urandom % 8 == 0)
                queue_word(CMD_LOAD, 16'h0000, 16'($urandom));
            m = $urandom_range(2, 16);
            for (i = 0; i < m; i++)
            begin
                r = $urandom % 100;
                k = loaded[$urandom_range(0, loaded.size() - 1)];
                if (r < 70)
                    k = k;
                else if (r < 80)
                    k = k + 16'd1;
                else if (r < 95)
                    k = 16'($urandom_range(1, 65535));
                else
                    k = '0;
                queue_word(CMD_LOOKUP, k, 16'($urandom));
            end
            tables++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (word_q.size() != 0 || in_valid)
            @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && answer_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
